// ===== rtl/core/ips_patch_stream_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// IPS patch stream parser assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef IPS_PATCH_STREAM_PARSER_CORE_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge
`define IPSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge
`define IPSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define IPSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ipsp_pkg.sv =====
// ----------------------------------------------------------------------------
// IPS patch stream parser package
// Phase codes, status codes, header signature and shared structs.
// ----------------------------------------------------------------------------
package ipsp_pkg;

  localparam int ADDRESS_BITS_DEF = 24;
  localparam int SIZE_W           = 25;
  localparam int PADDR_W          = 3;

  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 25'h100_0000;
  localparam logic [23:0]       END_MARK       = 24'h454F46;
  localparam logic [2:0]        HDR_LAST_IDX   = 3'd4;

  // Parser phases
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_OFFSET   = 3'd1;
  localparam logic [2:0] PH_LENGTH   = 3'd2;
  localparam logic [2:0] PH_LITERAL  = 3'd3;
  localparam logic [2:0] PH_RUNCOUNT = 3'd4;
  localparam logic [2:0] PH_RUNVALUE = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  // Outcome codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Register index
  localparam logic REG_IMAGE_SIZE = 1'b0;

  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       last;
  } ipsp_step_t;

  typedef struct packed {
    logic        valid;
    logic        write_valid;
    logic [23:0] address;
    logic [7:0]  value;
    logic [15:0] count;
    logic        finished;
    logic [1:0]  status;
  } ipsp_result_t;

  // "PATCH"
  function automatic logic [7:0] hdr_byte(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h43;
      default: c = 8'h48;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ipsp_cfg.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser configuration register
// APB-style port holding the image size register.
// ----------------------------------------------------------------------------
module ipsp_cfg
  import ipsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [SIZE_W-1:0]  image_size
);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);

  always_comb begin
    size_nxt = size_r;
    if (wr_en) begin
      size_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= IMAGE_SIZE_RST;
    end else begin
      size_r <= size_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_IMAGE_SIZE) begin
      prdata = {{(32-SIZE_W){1'b0}}, size_r};
    end
  end

  assign image_size = size_r;

endmodule

// ===== rtl/core/ipsp_fsm.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser state machine
// Parser state registers and the one-byte step that forms each result.
// ----------------------------------------------------------------------------
`include "ips_patch_stream_parser_core_macros.svh"

module ipsp_fsm
  import ipsp_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] image_size,
  input  ipsp_step_t        step,
  output ipsp_result_t      res
);

  localparam logic [SIZE_W-1:0] CAP = SIZE_W'(1) << ADDRESS_BITS;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [23:0] offs_r, offs_nxt;
  logic [15:0] len_r, len_nxt;
  logic        latched_r, latched_nxt;
  logic        past_end_r, past_end_nxt;

  logic [SIZE_W-1:0] lim;
  logic [SIZE_W-1:0] room;
  logic [23:0]       offs_shift;
  logic [15:0]       len_shift;
  logic [15:0]       len_dec;
  logic [2:0]        cnt_inc;
  logic              in_range;

  assign lim        = (image_size < CAP) ? image_size : CAP;
  assign offs_shift = {offs_r[15:0], step.data};
  assign len_shift  = {len_r[7:0], step.data};
  assign len_dec    = len_r - 16'd1;
  assign cnt_inc    = cnt_r + 3'd1;
  assign in_range   = !past_end_r && ({1'b0, offs_r} < lim);
  assign room       = lim - {1'b0, offs_r};

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    offs_nxt     = offs_r;
    len_nxt      = len_r;
    latched_nxt  = latched_r;
    past_end_nxt = past_end_r;
    res          = '0;

    if (step.fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (step.data != hdr_byte(cnt_r)) begin
            res.finished = 1'b1;
            res.status   = ST_BAD;
          end else if (cnt_r == HDR_LAST_IDX) begin
            phase_nxt = PH_OFFSET;
            cnt_nxt   = 3'd0;
            offs_nxt  = 24'd0;
            if (step.last) begin
              res.finished = 1'b1;
              res.status   = ST_TRUNC;
            end
          end else begin
            cnt_nxt = cnt_inc;
            // short header counts as a bad header
            if (step.last) begin
              res.finished = 1'b1;
              res.status   = ST_BAD;
            end
          end
        end
        PH_OFFSET: begin
          offs_nxt = offs_shift;
          cnt_nxt  = cnt_inc;
          if (cnt_inc >= 3'd3) begin
            cnt_nxt = 3'd0;
            if (offs_shift == END_MARK) begin
              res.finished = 1'b1;
              res.status   = ST_OK;
            end else begin
              phase_nxt    = PH_LENGTH;
              len_nxt      = 16'd0;
              past_end_nxt = 1'b0;
            end
          end
          if (!res.finished && step.last) begin
            res.finished = 1'b1;
            res.status   = ST_TRUNC;
          end
        end
        PH_LENGTH, PH_RUNCOUNT: begin
          len_nxt = len_shift;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 3'd2) begin
            cnt_nxt = 3'd0;
            if (phase_r == PH_RUNCOUNT) begin
              phase_nxt = PH_RUNVALUE;
            end else if (len_shift != 16'd0) begin
              phase_nxt = PH_LITERAL;
            end else begin
              // zero length: run record follows
              phase_nxt = PH_RUNCOUNT;
              len_nxt   = 16'd0;
            end
          end
          if (step.last) begin
            res.finished = 1'b1;
            res.status   = ST_TRUNC;
          end
        end
        PH_LITERAL: begin
          if (in_range) begin
            res.write_valid = 1'b1;
            res.address     = offs_r;
            res.value       = step.data;
            res.count       = 16'd1;
            if (offs_r == 24'hFF_FFFF) begin
              past_end_nxt = 1'b1;
            end else begin
              offs_nxt = offs_r + 24'd1;
            end
          end
          len_nxt = len_dec;
          if (len_dec == 16'd0) begin
            phase_nxt = PH_OFFSET;
            cnt_nxt   = 3'd0;
            offs_nxt  = 24'd0;
          end
          if (step.last) begin
            res.finished = 1'b1;
            res.status   = ST_TRUNC;
          end
        end
        PH_RUNVALUE: begin
          if ((len_r != 16'd0) && in_range) begin
            res.write_valid = 1'b1;
            res.address     = offs_r;
            res.value       = step.data;
            // clip the run at the image end
            res.count       = ({{(SIZE_W-16){1'b0}}, len_r} < room) ? len_r : room[15:0];
          end
          phase_nxt = PH_OFFSET;
          cnt_nxt   = 3'd0;
          offs_nxt  = 24'd0;
          if (step.last) begin
            res.finished = 1'b1;
            res.status   = ST_TRUNC;
          end
        end
        default: begin
          // outcome latched: drop bytes until the final one rearms
          if (step.last) begin
            phase_nxt   = PH_HEADER;
            cnt_nxt     = 3'd0;
            latched_nxt = 1'b0;
          end
        end
      endcase

      if (res.finished) begin
        cnt_nxt = 3'd0;
        if (step.last) begin
          phase_nxt   = PH_HEADER;
          latched_nxt = 1'b0;
        end else begin
          phase_nxt   = PH_DONE;
          latched_nxt = 1'b1;
        end
      end
      res.valid = res.write_valid || res.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= 3'd0;
      offs_r     <= 24'd0;
      len_r      <= 16'd0;
      latched_r  <= 1'b0;
      past_end_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      offs_r     <= offs_nxt;
      len_r      <= len_nxt;
      latched_r  <= latched_nxt;
      past_end_r <= past_end_nxt;
    end
  end

  `IPSP_ASSERT_NOW(a_hdr_cnt, clk, rst_n, phase_r == PH_HEADER, cnt_r <= HDR_LAST_IDX, "header count out of range")
  `IPSP_ASSERT_NOW(a_latch_phase, clk, rst_n, 1'b1, latched_r == (phase_r == PH_DONE), "latched flag disagrees with phase")
  `IPSP_ASSERT_NOW(a_done_quiet, clk, rst_n, step.fire && (phase_r == PH_DONE), !res.valid, "result while outcome latched")
  `IPSP_ASSERT_NEXT(a_fin_latch, clk, rst_n, step.fire && res.finished && !step.last, phase_r == PH_DONE, "outcome not latched")
  `IPSP_ASSERT_NOW(a_status_zero, clk, rst_n, !res.finished, res.status == ST_OK, "status set without finish")

endmodule

// ===== rtl/core/ips_patch_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// IPS patch stream parser core
// Path: an accepted byte is held in the input register, and its result is
// registered in the result register, from which it transfers on out_ready.
// Throughput: one byte per cycle when the output is not stalled; the parser
// step is a single pass between the input register and the result register.
// Reset: synchronous, active low; parser returns to the header phase and the
// image size register to 2^24.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_core
  import ipsp_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_patch_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_write_valid,
  output logic [23:0]        out_write_address,
  output logic [7:0]         out_write_value,
  output logic [15:0]        out_write_count,
  output logic               out_finished,
  output logic [1:0]         out_status
);

  logic [SIZE_W-1:0] image_size;
  ipsp_step_t        step;
  ipsp_result_t      res;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        out_vld_r, out_vld_nxt;
  logic        fire;
  ipsp_result_t out_r;

  ipsp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .image_size (image_size)
  );

  // advance the held byte when the result register is free or is being read out
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  assign step.fire = fire;
  assign step.data = byte_r;
  assign step.last = last_r;

  ipsp_fsm #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .image_size (image_size),
    .step       (step),
    .res        (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = res.valid;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers: hold until the next transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_patch_byte;
      last_r <= in_last_byte;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_write_valid   = out_r.write_valid;
  assign out_write_address = out_r.address;
  assign out_write_value   = out_r.value;
  assign out_write_count   = out_r.count;
  assign out_finished      = out_r.finished;
  assign out_status        = out_r.status;

endmodule
